// ===== rtl/core/pffr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pffr_pkg;

    // default sizes of the page table and the frame-owner table
    localparam int PAGES_DEF  = 1024;
    localparam int FRAMES_DEF = 256;

    // fixed field widths
    localparam int PAGE_W     = 10;
    localparam int FRAME_W    = 8;
    localparam int RIGHTS_W   = 2;
    localparam int ACTION_W   = 2;
    localparam int CNT_W      = 32;
    localparam int NFR_W      = 9;
    localparam int LFSR_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 120;

    // remainder unit: quotient bits retired per cycle
    localparam int MOD_STEPS  = 4;

    // reset value of the frames-in-use register
    localparam logic [NFR_W-1:0] FRAMES_RST = 9'd256;

    // page rights
    localparam logic [RIGHTS_W-1:0] RIGHT_NONE = 2'd0;
    localparam logic [RIGHTS_W-1:0] RIGHT_READ = 2'd1;
    localparam logic [RIGHTS_W-1:0] RIGHT_RW   = 2'd3;

    // result actions
    localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_UPGRADE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_NONE    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 2'd2;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_VICTIM,
        ST_OWNER,
        ST_EVICT,
        ST_UPDATE,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic accept;
        logic lookup;
        logic owner_chk;
        logic evict;
        logic update;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic in_range;
        logic victim_ok;
        logic need_evict;
        logic out_free;
    } t_status;

    // result item, last field in the lowest bits
    typedef struct packed {
        logic [CNT_W-1:0]    write_total;
        logic [CNT_W-1:0]    read_total;
        logic [CNT_W-1:0]    fault_total;
        logic [RIGHTS_W-1:0] new_rights;
        logic                write_back;
        logic [PAGE_W-1:0]   evicted_page;
        logic                evicted_valid;
        logic [FRAME_W-1:0]  frame;
        logic [ACTION_W-1:0] action;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/page_fault_frame_replacer_core.sv =====
// Page-fault frame replacer.
// Input channel s_axis: one item per page fault, the page number in tdata.
// Output channel m_axis: one result item per accepted fault: the action taken,
// the frame that now holds the page, the evicted owner and write-back flag,
// the page's new rights and the fault, disk-read and write-back totals.
// Configuration channel i_cfg_*: index 0 policy (0 round-robin, 1 lfsr),
// index 1 frames in use, index 2 lfsr seed (loaded at once).
// One item is worked at a time; the next item is accepted only once the result of
// the last one has been loaded into the output register. Pseudo-random items also
// wait for the remainder unit that reduces the lfsr modulo the frames in use.
// The page table and frame-owner table each sit behind one memory with one
// read and one write port, so the lookups and write-backs run one after another.
// After reset a clearing pass over every page and frame address
// empties both tables; no item is accepted until it ends, while configuration
// writes are taken at any time.
// A finished result waits in an output register; the next item is accepted
// while it waits, and that item's result waits in turn until m_axis_tready.
`timescale 1ns / 1ps
`default_nettype none

module page_fault_frame_replacer_core
    import pffr_pkg::*;
#(
    parameter int PAGES  = PAGES_DEF,
    parameter int FRAMES = FRAMES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // fault items
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // page[9:0], zero pad
    // result items
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // action[1:0] frame[9:2] evicted_valid[10] evicted_page[20:11]
    // write_back[21] new_rights[23:22] fault_total[55:24]
    // read_total[87:56] write_total[119:88]
    output logic      [OUT_DATA_W-1:0] m_axis_tdata
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    pffr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pffr_dp #(
        .PAGES  (PAGES),
        .FRAMES (FRAMES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_page      (s_axis_tdata[PAGE_W-1:0]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded over a pending result");

    // no item enters while the tables are being cleared
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |-> !s_axis_tready)
        else $error("input ready during clearing pass");

    // only one item in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |=> !s_axis_tready)
        else $error("second item accepted while one is in flight");

    // table writes for an item happen only for an in-range page
    a_update_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.update || cmd.evict) |-> status.in_range)
        else $error("table write for an out-of-range page");

endmodule

`default_nettype wire

// ===== rtl/core/pffr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pffr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/pffr_mod.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pffr_mod
    import pffr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [LFSR_W-1:0] i_dividend,
    input  wire logic [NFR_W-1:0]  i_divisor,
    output logic                   o_done,
    output logic      [NFR_W-1:0]  o_rem
);

    localparam int CYCLES = LFSR_W / MOD_STEPS;
    localparam int CNT_BW = (CYCLES > 1) ? $clog2(CYCLES) : 1;

    logic              r_busy;
    logic              r_done;
    logic [CNT_BW-1:0] r_cnt;
    logic [LFSR_W-1:0] r_num;
    logic [NFR_W-1:0]  r_rem;
    logic [NFR_W-1:0]  r_den;
    logic [NFR_W-1:0]  n_rem;
    logic [NFR_W:0]    t_part;

    // restoring remainder, several dividend bits per cycle
    always_comb begin
        n_rem  = r_rem;
        t_part = '0;
        for (int k = 0; k < MOD_STEPS; k++) begin
            t_part = {n_rem, r_num[LFSR_W-1-k]};
            if (t_part >= {1'b0, r_den}) begin
                n_rem = NFR_W'(t_part - {1'b0, r_den});
            end else begin
                n_rem = t_part[NFR_W-1:0];
            end
        end
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_dividend;
                r_rem  <= '0;
                r_den  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_num <= {r_num[LFSR_W-1-MOD_STEPS:0], MOD_STEPS'(0)};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BW'(CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== rtl/core/pffr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pffr_ctrl
    import pffr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_status.clear_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                n_state = i_status.in_range ? ST_VICTIM : ST_OUT;
            end
            ST_VICTIM: begin
                if (i_status.victim_ok) n_state = ST_OWNER;
            end
            ST_OWNER: begin
                n_state = i_status.need_evict ? ST_EVICT : ST_UPDATE;
            end
            ST_EVICT: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_LOOKUP: begin
                o_cmd.lookup = 1'b1;
            end
            ST_VICTIM: begin
            end
            ST_OWNER: begin
                o_cmd.owner_chk = 1'b1;
            end
            ST_EVICT: begin
                o_cmd.evict = 1'b1;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            ST_OUT: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/pffr_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pffr_dp
    import pffr_pkg::*;
#(
    parameter int PAGES  = PAGES_DEF,
    parameter int FRAMES = FRAMES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [PAGE_W-1:0]     i_page,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic      [OUT_DATA_W-1:0] o_out_data
);

    localparam int PW    = $clog2(PAGES);
    localparam int FW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int IW    = ((PW > PAGE_W) ? PW : PAGE_W) + 1;
    localparam int CLR_N = (PAGES > FRAMES) ? PAGES : FRAMES;
    localparam int CW    = $clog2(CLR_N);
    localparam int CMP_W = 18;
    localparam int PE_W  = RIGHTS_W + FW;
    localparam int OE_W  = 1 + PW;

    // configuration and selection state
    logic              r_policy;
    logic [NFR_W-1:0]  r_frames;
    logic [LFSR_W-1:0] r_lfsr;
    logic [FW-1:0]     r_fifo;
    logic [CW-1:0]     r_clr;

    // item state
    logic              r_in_range;
    logic [PW-1:0]     r_page;
    logic [FW-1:0]     r_victim;
    logic              r_victim_ok;
    logic [RIGHTS_W-1:0] r_ent_rights;
    logic [FW-1:0]     r_ent_frame;
    logic              r_ev_valid;
    logic [PW-1:0]     r_ev_page;
    logic              r_wb;
    logic [CNT_W-1:0]  r_fault_cnt;
    logic [CNT_W-1:0]  r_read_cnt;
    logic [CNT_W-1:0]  r_write_cnt;
    logic              r_out_valid;
    t_result           r_out;

    // combinational helpers
    logic [IW-1:0]     pg_wide;
    logic              pg_in_range;
    logic [NFR_W-1:0]  n_act;
    logic [FW-1:0]     fifo_v;
    logic [FW-1:0]     fifo_next;
    logic              lfsr_fb;
    logic [LFSR_W-1:0] lfsr_step;
    logic              mod_start;
    logic              mod_done;
    logic [NFR_W-1:0]  mod_rem;
    logic              out_free;
    t_result           n_out;
    logic [PW+PAGE_W-1:0] ev_wide;
    logic [FW+FRAME_W-1:0] fr_wide;

    // memory ports
    logic              pt_we;
    logic [PW-1:0]     pt_waddr;
    logic [PE_W-1:0]   pt_wdata;
    logic [PW-1:0]     pt_raddr;
    logic [PE_W-1:0]   pt_rdata;
    logic              ot_we;
    logic [FW-1:0]     ot_waddr;
    logic [OE_W-1:0]   ot_wdata;
    logic [OE_W-1:0]   ot_rdata;

    // page range check and table index
    assign pg_wide     = IW'(i_page);
    assign pg_in_range = pg_wide < IW'(PAGES);

    // frames in use clamped to one..FRAMES
    always_comb begin
        if (r_frames == '0) begin
            n_act = NFR_W'(1);
        end else if (CMP_W'(r_frames) > CMP_W'(FRAMES)) begin
            n_act = NFR_W'(FRAMES);
        end else begin
            n_act = r_frames;
        end
    end

    // round-robin victim and pointer advance
    always_comb begin
        fifo_v = (CMP_W'(r_fifo) >= CMP_W'(n_act)) ? '0 : r_fifo;
        if (CMP_W'(fifo_v) + CMP_W'(1) >= CMP_W'(n_act)) begin
            fifo_next = '0;
        end else begin
            fifo_next = fifo_v + FW'(1);
        end
    end

    // lfsr x^16+x^14+x^13+x^11+1, shifted right
    assign lfsr_fb   = r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5];
    assign lfsr_step = {lfsr_fb, r_lfsr[LFSR_W-1:1]};
    assign mod_start = i_cmd.accept && pg_in_range && r_policy;

    pffr_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (lfsr_step),
        .i_divisor  (n_act),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // page table: rights over frame
    always_comb begin
        pt_we    = 1'b0;
        pt_waddr = r_page;
        pt_wdata = '0;
        if (i_cmd.clear) begin
            pt_we    = CMP_W'(r_clr) < CMP_W'(PAGES);
            pt_waddr = r_clr[PW-1:0];
        end else if (i_cmd.evict) begin
            pt_we    = 1'b1;
            pt_waddr = r_ev_page;
        end else if (i_cmd.update) begin
            if (r_ent_rights == RIGHT_NONE) begin
                pt_we    = 1'b1;
                pt_wdata = {RIGHT_READ, r_victim};
            end else if (r_ent_rights == RIGHT_READ) begin
                pt_we    = 1'b1;
                pt_wdata = {RIGHT_RW, r_ent_frame};
            end
        end
    end

    // old owner is looked up while the owner entry is checked
    assign pt_raddr = i_cmd.owner_chk ? ot_rdata[PW-1:0] : pg_wide[PW-1:0];

    pffr_ram #(
        .WIDTH (PE_W),
        .DEPTH (PAGES)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (pt_waddr),
        .i_wdata (pt_wdata),
        .i_raddr (pt_raddr),
        .o_rdata (pt_rdata)
    );

    // frame-owner table: valid over page
    always_comb begin
        ot_we    = 1'b0;
        ot_waddr = r_victim;
        ot_wdata = '0;
        if (i_cmd.clear) begin
            ot_we    = CMP_W'(r_clr) < CMP_W'(FRAMES);
            ot_waddr = r_clr[FW-1:0];
        end else if (i_cmd.update && r_ent_rights == RIGHT_NONE) begin
            ot_we    = 1'b1;
            ot_wdata = {1'b1, r_page};
        end
    end

    pffr_ram #(
        .WIDTH (OE_W),
        .DEPTH (FRAMES)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (ot_we),
        .i_waddr (ot_waddr),
        .i_wdata (ot_wdata),
        .i_raddr (r_victim),
        .o_rdata (ot_rdata)
    );

    // configuration, lfsr, pointer, sweep counter and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy    <= 1'b0;
            r_frames    <= FRAMES_RST;
            r_lfsr      <= LFSR_W'(1);
            r_fifo      <= '0;
            r_clr       <= '0;
            r_victim_ok <= 1'b0;
            r_fault_cnt <= '0;
            r_read_cnt  <= '0;
            r_write_cnt <= '0;
        end else begin
            if (i_cmd.clear && !o_status.clear_done) begin
                r_clr <= r_clr + CW'(1);
            end
            if (i_cmd.accept && pg_in_range) begin
                r_fault_cnt <= r_fault_cnt + CNT_W'(1);
                if (r_policy) begin
                    r_lfsr      <= lfsr_step;
                    r_victim_ok <= 1'b0;
                end else begin
                    r_fifo      <= fifo_next;
                    r_victim_ok <= 1'b1;
                end
            end else if (mod_done) begin
                r_victim_ok <= 1'b1;
            end
            if (i_cmd.evict && pt_rdata[PE_W-1 -: RIGHTS_W] == RIGHT_RW) begin
                r_write_cnt <= r_write_cnt + CNT_W'(1);
            end
            if (i_cmd.update && r_ent_rights == RIGHT_NONE) begin
                r_read_cnt <= r_read_cnt + CNT_W'(1);
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_POLICY: r_policy <= i_cfg_data[0];
                    CFG_FRAMES: r_frames <= i_cfg_data[NFR_W-1:0];
                    CFG_SEED: begin
                        r_lfsr <= (i_cfg_data == '0) ? LFSR_W'(1) : i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in_range <= pg_in_range;
            r_page     <= pg_wide[PW-1:0];
            r_ev_valid <= 1'b0;
            r_ev_page  <= '0;
            r_wb       <= 1'b0;
            if (!r_policy) begin
                r_victim <= fifo_v;
            end
        end
        if (mod_done) begin
            r_victim <= FW'(mod_rem);
        end
        if (i_cmd.lookup) begin
            r_ent_rights <= pt_rdata[PE_W-1 -: RIGHTS_W];
            r_ent_frame  <= pt_rdata[FW-1:0];
        end
        if (i_cmd.owner_chk) begin
            r_ev_valid <= o_status.need_evict;
            r_ev_page  <= ot_rdata[PW-1:0];
        end
        if (i_cmd.evict) begin
            r_wb <= pt_rdata[PE_W-1 -: RIGHTS_W] == RIGHT_RW;
        end
    end

    // result fields
    always_comb begin
        ev_wide = (PW + PAGE_W)'(r_ev_page);
        fr_wide = (FW + FRAME_W)'(r_ent_frame);
        n_out   = '0;
        n_out.fault_total = r_fault_cnt;
        n_out.read_total  = r_read_cnt;
        n_out.write_total = r_write_cnt;
        n_out.action      = ACT_NONE;
        if (r_in_range) begin
            if (r_ent_rights == RIGHT_NONE) begin
                fr_wide             = (FW + FRAME_W)'(r_victim);
                n_out.action        = ACT_LOAD;
                n_out.frame         = fr_wide[FRAME_W-1:0];
                n_out.evicted_valid = r_ev_valid;
                n_out.evicted_page  = r_ev_valid ? ev_wide[PAGE_W-1:0] : '0;
                n_out.write_back    = r_wb;
                n_out.new_rights    = RIGHT_READ;
            end else if (r_ent_rights == RIGHT_READ) begin
                n_out.action     = ACT_UPGRADE;
                n_out.frame      = fr_wide[FRAME_W-1:0];
                n_out.new_rights = RIGHT_RW;
            end else begin
                n_out.frame      = fr_wide[FRAME_W-1:0];
                n_out.new_rights = r_ent_rights;
            end
        end
    end

    // output register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // status
    assign o_status.clear_done = r_clr == CW'(CLR_N - 1);
    assign o_status.in_range   = r_in_range;
    assign o_status.victim_ok  = r_victim_ok;
    assign o_status.need_evict = (r_ent_rights == RIGHT_NONE) && ot_rdata[OE_W-1];
    assign o_status.out_free   = out_free;

endmodule

`default_nettype wire

// ===== verif/tb_page_fault_frame_replacer_core.sv =====
`timescale 1ns / 1ps

module tb_page_fault_frame_replacer_core;
    import pffr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped index, must be ignored
    localparam int WATCHDOG_LIMIT = 4000;  // covers the table clearing pass after reset
    localparam int HOLD_CYCLES    = 200;
    localparam int SETTLE_CYCLES  = 30;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 95;

    // directed stimulus row: a register write or a fault item
    typedef struct {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        bit                    fixed;
        t_result               want;
    } t_plan_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tready = 1'b0;
    logic                  o_cfg_ready;
    logic                  s_axis_tready;
    logic                  m_axis_tvalid;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // shadow page table, frame owners, victim pickers and totals
    logic [RIGHTS_W-1:0] pg_rights [PAGES_DEF];
    logic [FRAME_W-1:0]  pg_frame [PAGES_DEF];
    bit                  owner_valid [FRAMES_DEF];
    logic [PAGE_W-1:0]   owner_page [FRAMES_DEF];
    int                  fifo_ptr = 0;
    logic [LFSR_W-1:0]   lfsr_q = 16'd1;
    logic [CNT_W-1:0]    fault_cnt = '0;
    logic [CNT_W-1:0]    read_cnt = '0;
    logic [CNT_W-1:0]    write_cnt = '0;
    bit                  cfg_policy = 1'b0;
    logic [NFR_W-1:0]    cfg_frames = FRAMES_RST;

    t_result   pending_results [$];
    t_plan_row plan [$];
    int        n_errors = 0;
    int        n_results = 0;
    int        idle_cycles = 0;
    bit        hold_req = 1'b0;
    bit        no_idle = 1'b0;

    page_fault_frame_replacer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // page[9:0], zero pad
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // action, frame, evicted_valid, evicted_page,
                                         // write_back, new_rights, fault/read/write totals
    );

    always #1 i_clk = ~i_clk;

    // frames actually in play: zero acts as one, oversize acts as the table size
    function automatic int frames_eff();
        if (cfg_frames == 0)
            return 1;
        if (cfg_frames > FRAMES_DEF)
            return FRAMES_DEF;
        return int'(cfg_frames);
    endfunction

    function automatic t_result mk_result(input int act, input int frame, input int evv,
                                          input int evp, input int wb, input int rights,
                                          input int faults, input int reads, input int writes);
        t_result r;
        r.action        = ACTION_W'(act);
        r.frame         = FRAME_W'(frame);
        r.evicted_valid = evv[0];
        r.evicted_page  = PAGE_W'(evp);
        r.write_back    = wb[0];
        r.new_rights    = RIGHTS_W'(rights);
        r.fault_total   = CNT_W'(faults);
        r.read_total    = CNT_W'(reads);
        r.write_total   = CNT_W'(writes);
        return r;
    endfunction

    // victim choice, eviction and rights update for one fault
    function automatic t_result predict_fault(input logic [PAGE_W-1:0] pg);
        t_result           r;
        int                n;
        int                victim;
        logic              fb;
        logic [PAGE_W-1:0] old;
        n = frames_eff();
        r = '0;
        r.action = ACT_NONE;
        fault_cnt++;
        if (cfg_policy) begin
            fb = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
            lfsr_q = {fb, lfsr_q[LFSR_W-1:1]};
            victim = int'(lfsr_q) % n;
        end else begin
            victim = (fifo_ptr >= n) ? 0 : fifo_ptr;
            fifo_ptr = (victim + 1 >= n) ? 0 : victim + 1;
        end
        r.frame = pg_frame[pg];
        r.new_rights = pg_rights[pg];
        if (pg_rights[pg] == RIGHT_NONE) begin
            if (owner_valid[victim]) begin
                old = owner_page[victim];
                r.evicted_valid = 1'b1;
                r.evicted_page = old;
                if (pg_rights[old] == RIGHT_RW) begin
                    r.write_back = 1'b1;
                    write_cnt++;
                end
                pg_rights[old] = RIGHT_NONE;
                pg_frame[old] = '0;
            end
            owner_valid[victim] = 1'b1;
            owner_page[victim] = pg;
            read_cnt++;
            pg_rights[pg] = RIGHT_READ;
            pg_frame[pg] = FRAME_W'(victim);
            r.action = ACT_LOAD;
            r.frame = FRAME_W'(victim);
            r.new_rights = RIGHT_READ;
        end else if (pg_rights[pg] == RIGHT_READ) begin
            pg_rights[pg] = RIGHT_RW;
            r.action = ACT_UPGRADE;
            r.new_rights = RIGHT_RW;
        end
        r.fault_total = fault_cnt;
        r.read_total = read_cnt;
        r.write_total = write_cnt;
        return r;
    endfunction

    function automatic t_plan_row item_row(input int pg);
        t_plan_row row;
        row = '{default: '0};
        row.data = CFG_DATA_W'(pg);
        return row;
    endfunction

    function automatic t_plan_row fixed_row(input int pg, input t_result want);
        t_plan_row row;
        row = item_row(pg);
        row.fixed = 1'b1;
        row.want = want;
        return row;
    endfunction

    function automatic t_plan_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        t_plan_row row;
        row = '{default: '0};
        row.is_reg = 1'b1;
        row.idx = idx;
        row.data = data;
        return row;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch: %s", msg);
        n_errors++;
    endtask

    task automatic compare_field(input string name, input logic [CNT_W-1:0] got,
                                 input logic [CNT_W-1:0] want);
        if (got !== want)
            flag_mismatch($sformatf("result %0d %s got %0h want %0h",
                                    n_results, name, got, want));
    endtask

    task automatic check_result(input logic [OUT_DATA_W-1:0] data);
        t_result got;
        t_result want;
        if (pending_results.size() == 0) begin
            flag_mismatch($sformatf("unexpected result item %h", data));
            return;
        end
        got = t_result'(data);
        want = pending_results.pop_front();
        n_results++;
        compare_field("action", CNT_W'(got.action), CNT_W'(want.action));
        compare_field("frame", CNT_W'(got.frame), CNT_W'(want.frame));
        compare_field("evicted_valid", CNT_W'(got.evicted_valid), CNT_W'(want.evicted_valid));
        compare_field("evicted_page", CNT_W'(got.evicted_page), CNT_W'(want.evicted_page));
        compare_field("write_back", CNT_W'(got.write_back), CNT_W'(want.write_back));
        compare_field("new_rights", CNT_W'(got.new_rights), CNT_W'(want.new_rights));
        compare_field("fault_total", got.fault_total, want.fault_total);
        compare_field("read_total", got.read_total, want.read_total);
        compare_field("write_total", got.write_total, want.write_total);
    endtask

    // offer one fault item; valid stays high afterwards so back-to-back items need no toggle
    task automatic send_fault(input logic [PAGE_W-1:0] pg, input bit fixed,
                              input t_result want);
        int      gap;
        t_result predicted;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_DATA_W-PAGE_W){1'b0}}, pg};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = predict_fault(pg);
        pending_results.push_back(fixed ? want : predicted);
    endtask

    // stop offering and wait until every result is back
    task automatic drain_wait();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // register write; valid is left high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_POLICY: cfg_policy = data[0];
            CFG_FRAMES: cfg_frames = data[NFR_W-1:0];
            CFG_SEED:   lfsr_q = (data == '0) ? 16'd1 : data;
            default: ;
        endcase
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin : result_sink
        int gap;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, 6);
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            // valid is unknown until the first reset edge
            while (m_axis_tvalid !== 1'b1) @(posedge i_clk);
            check_result(m_axis_tdata);
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_page_fault_frame_replacer_core failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        bit                reg_open;
        int                fr;
        int                span;
        int                base;
        logic [PAGE_W-1:0] pg;

        foreach (pg_rights[i]) begin
            pg_rights[i] = RIGHT_NONE;
            pg_frame[i] = '0;
        end
        foreach (owner_valid[i]) begin
            owner_valid[i] = 1'b0;
            owner_page[i] = '0;
        end

        // defaults after reset: fifo, all frames, first load, upgrade, already read-write
        plan.push_back(fixed_row(0,
            mk_result(ACT_LOAD, 0, 0, 0, 0, RIGHT_READ, 1, 1, 0)));
        plan.push_back(fixed_row(1023,
            mk_result(ACT_LOAD, 1, 0, 0, 0, RIGHT_READ, 2, 2, 0)));
        plan.push_back(fixed_row(0,
            mk_result(ACT_UPGRADE, 0, 0, 0, 0, RIGHT_RW, 3, 2, 0)));
        plan.push_back(fixed_row(0,
            mk_result(ACT_NONE, 0, 0, 0, 0, RIGHT_RW, 4, 2, 0)));
        // zero frames acts as one, stale pointer selects frame 0, dirty eviction
        plan.push_back(reg_row(CFG_FRAMES, 16'd0));
        plan.push_back(fixed_row(5,
            mk_result(ACT_LOAD, 0, 1, 0, 1, RIGHT_READ, 5, 3, 1)));
        plan.push_back(fixed_row(0,
            mk_result(ACT_LOAD, 0, 1, 5, 0, RIGHT_READ, 6, 4, 1)));
        plan.push_back(fixed_row(1023,
            mk_result(ACT_UPGRADE, 1, 0, 0, 0, RIGHT_RW, 7, 4, 1)));
        // three frames via a value with junk upper bits, fifo wrap
        plan.push_back(reg_row(CFG_FRAMES, 16'hFE03));
        plan.push_back(item_row(2));
        plan.push_back(item_row(3));
        plan.push_back(item_row(4));
        plan.push_back(item_row(1023));
        plan.push_back(item_row(2));
        // oversize frame count acts as the full table
        plan.push_back(reg_row(CFG_FRAMES, 16'h01FF));
        plan.push_back(item_row(512));
        plan.push_back(item_row(3));
        // random policy from a zero seed, then a single frame
        plan.push_back(reg_row(CFG_SEED, 16'h0000));
        plan.push_back(reg_row(CFG_POLICY, 16'h0001));
        plan.push_back(item_row(600));
        plan.push_back(item_row(601));
        plan.push_back(item_row(600));
        plan.push_back(item_row(600));
        plan.push_back(reg_row(CFG_FRAMES, 16'd1));
        plan.push_back(item_row(700));
        plan.push_back(item_row(701));
        plan.push_back(item_row(700));
        // all-ones seed, full table, unmapped index ignored
        plan.push_back(reg_row(CFG_SEED, 16'hFFFF));
        plan.push_back(reg_row(CFG_FRAMES, 16'd256));
        plan.push_back(reg_row(CFG_SPARE, 16'hFFFF));
        plan.push_back(item_row(1023));
        plan.push_back(item_row(0));
        plan.push_back(item_row(512));
        plan.push_back(item_row(341));
        plan.push_back(item_row(682));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk
        reg_open = 1'b0;
        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                drain_wait();
                write_reg(plan[i].idx, plan[i].data);
                reg_open = 1'b1;
            end else begin
                if (reg_open) begin
                    i_cfg_valid <= 1'b0;
                    reg_open = 1'b0;
                end
                send_fault(plan[i].data[PAGE_W-1:0], plan[i].fixed, plan[i].want);
            end
        end

        // random phases: new settings, then faults mostly over a small working set
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_wait();
            write_reg(CFG_POLICY, CFG_DATA_W'($urandom));
            case ($urandom_range(0, 7))
                0:       fr = $urandom_range(1, 4);
                1, 2, 3: fr = $urandom_range(2, 16);
                4:       fr = 256;
                5:       fr = $urandom_range(17, 255);
                default: fr = $urandom_range(0, 65535);
            endcase
            write_reg(CFG_FRAMES, CFG_DATA_W'(fr));
            if ($urandom_range(0, 1) == 0)
                write_reg(CFG_SEED, ($urandom_range(0, 5) == 0) ? 16'h0000
                                                                : CFG_DATA_W'($urandom));
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
            i_cfg_valid <= 1'b0;

            no_idle = (ph % 4 == 2);
            if (ph == 2)
                hold_req = 1'b1;
            span = frames_eff() + frames_eff() / 2 + 2;
            base = $urandom_range(0, PAGES_DEF - 1);
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 4) == 0)
                    pg = PAGE_W'($urandom_range(0, PAGES_DEF - 1));
                else
                    pg = PAGE_W'((base + $urandom_range(0, span - 1)) % PAGES_DEF);
                send_fault(pg, 1'b0, t_result'('0));
            end
        end

        drain_wait();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("tb_page_fault_frame_replacer_core passed");
        else
            $display("tb_page_fault_frame_replacer_core failed");
        $finish;
    end

endmodule
